[rtl/utf8_text_normalizer_assert.svh]
// Assertion macros used by the checker in utn_checker.sv.
`ifndef UTF8_TEXT_NORMALIZER_ASSERT_SVH
`define UTF8_TEXT_NORMALIZER_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define UTN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_text_normalizer check failed");

// Check the consequent in the cycle after the antecedent.
`define UTN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_text_normalizer check failed");

`endif

[rtl/utn_pkg.sv]
package utn_pkg;

    localparam int unsigned NumSlots = 4;
    localparam int unsigned HeldDepth = 3;

    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChHyphen = 8'h2D;
    localparam logic [7:0] LeadC3   = 8'hC3;
    localparam logic [7:0] ContLo   = 8'h80;
    localparam logic [7:0] ContHi   = 8'hBF;
    localparam logic [7:0] UpperHi  = 8'h9E;
    localparam logic [7:0] MulSign  = 8'h97;
    localparam logic [7:0] CaseStep = 8'h20;

    typedef logic [2:0] t_cnt;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_req;

    typedef struct packed {
        logic [NumSlots-1:0][7:0] data;
        t_cnt                     count;
        logic                     last;
    } t_group;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + CaseStep : c;
    endfunction

endpackage

[rtl/utn_fifo.sv]
module utn_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utn_pkg::t_group i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output utn_pkg::t_group o_data
);

    utn_pkg::t_group r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/utn_front.sv]
module utn_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  utn_pkg::t_in_req i_in,
    output logic             o_push,
    output utn_pkg::t_group  o_group
);

    logic [7:0] r_held [utn_pkg::HeldDepth];
    logic [1:0] r_held_cnt;
    logic       r_prev;

    logic [7:0] n_held [utn_pkg::HeldDepth];
    logic [1:0] n_held_cnt;

    logic [7:0]      w_q [utn_pkg::NumSlots];
    logic [2:0]      w_n;
    logic [2:0]      w_h;
    logic [2:0]      w_avail;
    logic [2:0]      w_need;
    logic [2:0]      w_take;
    logic [2:0]      w_idx;
    logic [2:0]      w_rest;
    logic [1:0]      w_nxt;
    logic            w_end;
    logic            w_stop;
    logic            w_prev;
    logic            w_e1;
    logic            w_e2;
    logic [7:0]      w_c;
    logic [7:0]      w_c2;
    logic [7:0]      w_b1;
    logic [7:0]      w_b2;
    utn_pkg::t_group w_grp;

    always_comb begin
        w_end = i_in.end_of_text;
        w_n   = {1'b0, r_held_cnt} + 3'd1;
        for (int i = 0; i < utn_pkg::NumSlots; i++) begin
            if (i < utn_pkg::HeldDepth && 2'(i) < r_held_cnt) begin
                w_q[i] = r_held[i];
            end else begin
                w_q[i] = i_in.in_byte;
            end
        end
        w_h     = 3'd0;
        w_stop  = 1'b0;
        w_prev  = r_prev;
        w_grp   = '0;
        w_avail = 3'd0;
        w_need  = 3'd1;
        w_take  = 3'd1;
        w_idx   = 3'd0;
        w_nxt   = 2'd0;
        w_e1    = 1'b0;
        w_e2    = 1'b0;
        w_c     = 8'h00;
        w_c2    = 8'h00;
        w_b1    = utn_pkg::ChSpace;
        w_b2    = utn_pkg::ChSpace;
        for (int s = 0; s < utn_pkg::NumSlots; s++) begin
            if (!w_stop && w_h < w_n) begin
                w_c     = w_q[w_h[1:0]];
                w_nxt   = w_h[1:0] + 2'd1;
                w_c2    = w_q[w_nxt];
                w_avail = w_n - w_h;
                w_take  = 3'd1;
                w_e1    = 1'b0;
                w_e2    = 1'b0;
                w_b1    = utn_pkg::ChSpace;
                w_b2    = utn_pkg::ChSpace;
                if (w_c[7] == 1'b0) begin
                    w_need = 3'd1;
                    if (w_c == utn_pkg::ChHyphen) begin
                        if (w_avail < 3'd2 && !w_end) begin
                            w_stop = 1'b1;
                        end else begin
                            w_e1 = 1'b1;
                            if (w_prev && w_avail >= 3'd2 && utn_pkg::is_alnum(w_c2)) begin
                                w_b1 = utn_pkg::ChHyphen;
                            end
                        end
                    end else begin
                        w_e1 = 1'b1;
                        if (utn_pkg::is_alnum(w_c)) begin
                            w_b1 = utn_pkg::to_lower(w_c);
                        end
                    end
                end else begin
                    if (w_c[7:5] == 3'b110) begin
                        w_need = 3'd2;
                    end else if (w_c[7:4] == 4'b1110) begin
                        w_need = 3'd3;
                    end else if (w_c[7:3] == 5'b11110) begin
                        w_need = 3'd4;
                    end else begin
                        w_need = 3'd1;
                    end
                    if (w_avail < w_need) begin
                        if (!w_end) begin
                            w_stop = 1'b1;
                        end else begin
                            w_e1 = 1'b1;
                        end
                    end else if (w_need == 3'd2) begin
                        w_e1   = 1'b1;
                        w_take = 3'd2;
                        if (w_c == utn_pkg::LeadC3 && w_c2 >= utn_pkg::ContLo &&
                            w_c2 <= utn_pkg::ContHi) begin
                            w_e2 = 1'b1;
                            w_b1 = w_c;
                            w_b2 = w_c2;
                            if (w_c2 <= utn_pkg::UpperHi && w_c2 != utn_pkg::MulSign) begin
                                w_b2 = w_c2 + utn_pkg::CaseStep;
                            end
                        end
                    end else begin
                        w_e1   = 1'b1;
                        w_take = w_need;
                    end
                end
                if (!w_stop) begin
                    if (w_e1 && w_grp.count < 3'd4) begin
                        w_grp.data[w_grp.count[1:0]] = w_b1;
                        w_grp.count = w_grp.count + 3'd1;
                    end
                    if (w_e2 && w_grp.count < 3'd4) begin
                        w_grp.data[w_grp.count[1:0]] = w_b2;
                        w_grp.count = w_grp.count + 3'd1;
                    end
                    w_idx  = w_h + w_take - 3'd1;
                    w_prev = utn_pkg::is_alnum(w_q[w_idx[1:0]]);
                    w_h    = w_h + w_take;
                end
            end
        end
        w_grp.last = w_end;
        w_rest     = w_n - w_h;
        n_held_cnt = w_end ? 2'd0 : (w_rest[2] ? 2'd3 : w_rest[1:0]);
    end

    always_comb begin
        for (int i = 0; i < utn_pkg::HeldDepth; i++) begin
            logic [2:0] src;
            src       = w_h + 3'(i);
            n_held[i] = w_q[src[1:0]];
        end
    end

    assign o_push  = i_accept && (w_grp.count != 3'd0);
    assign o_group = w_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_prev     <= 1'b0;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
            r_prev     <= w_end ? 1'b0 : w_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

[rtl/utn_back.sv]
module utn_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  utn_pkg::t_group   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output utn_pkg::t_out_req o_out
);

    logic [1:0]        r_idx;
    logic              r_valid;
    utn_pkg::t_out_req r_out;

    logic              w_load;
    logic              w_final;
    utn_pkg::t_cnt     w_idx_ext;

    assign w_idx_ext = {1'b0, r_idx} + 3'd1;
    assign w_final   = w_idx_ext >= i_head.count;
    assign w_load    = i_head_valid && (!r_valid || !i_out_stall);
    assign o_pop     = w_load && w_final;

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte <= i_head.data[r_idx];
            r_out.out_last <= i_head.last && w_final;
        end
    end

endmodule

[rtl/utf8_text_normalizer.sv]
// A deciding byte's first result is queued, then loaded into the output register.
// Throughput: one input byte per cycle with no output stall, at most one result per byte.
// Output: one byte per cycle unless stalled; a C3 pair or flushed tail is sent serially.
// A two-entry group queue between decode and output sets how far input runs ahead.
// Reset (i_rst_n low, synchronous) empties the queue, held bytes and output register.
module utf8_text_normalizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  utn_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output utn_pkg::t_out_req o_out
);

    logic            w_accept;
    logic            w_push;
    logic            w_full;
    logic            w_head_valid;
    logic            w_pop;
    utn_pkg::t_group w_group;
    utn_pkg::t_group w_head;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    utn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in),
        .o_push   (w_push),
        .o_group  (w_group)
    );

    utn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_group),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .i_pop   (w_pop),
        .o_data  (w_head)
    );

    utn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

[rtl/utn_checker.sv]
`include "utf8_text_normalizer_assert.svh"

module utn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input utn_pkg::t_in_req  i_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input utn_pkg::t_out_req o_out
);

    logic [7:0] w_b;
    logic       w_out_wait;
    logic       w_in_wait;
    logic       w_upper;
    logic       w_ascii_ok;

    assign w_b        = o_out.out_byte;
    assign w_out_wait = o_out_valid && i_out_stall;
    assign w_in_wait  = i_in_valid && o_in_stall;
    assign w_upper    = w_b >= 8'h41 && w_b <= 8'h5A;
    assign w_ascii_ok = w_b == utn_pkg::ChSpace || w_b == utn_pkg::ChHyphen ||
                        (w_b >= 8'h30 && w_b <= 8'h39) || (w_b >= 8'h61 && w_b <= 8'h7A);

    `UTN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid && $stable(o_out))
    `UTN_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, w_in_wait, i_in_valid && $stable(i_in))
    `UTN_ASSERT_IMP(a_no_upper, i_clk, i_rst_n, o_out_valid, !w_upper)
    `UTN_ASSERT_IMP(a_ascii_set, i_clk, i_rst_n, o_out_valid && !w_b[7], w_ascii_ok)

endmodule

bind utf8_text_normalizer utn_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[dv/utn_stream_checker.sv]
module utn_stream_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  utn_pkg::t_in_req  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  utn_pkg::t_out_req i_out,
    output int                o_fail_count,
    output int                o_pending
);
    import utn_pkg::*;

    logic [7:0] held_raw [3];
    int         held_cnt = 0;
    logic       prev_word_char = 1'b0;
    t_out_req   norm_bytes_q [$];
    int         mismatches = 0;

    function automatic logic word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + CaseStep;
        end
        return c;
    endfunction

    task automatic normalize_byte(input t_in_req req);
        logic [7:0] win [4];
        logic [7:0] out_bytes [4];
        logic [7:0] lead;
        logic [7:0] nxt;
        logic       next_ok;
        t_out_req   res;
        int         n;
        int         h;
        int         avail;
        int         take;
        int         need;
        int         cnt;

        for (int i = 0; i < 3; i++) begin
            win[i] = held_raw[i];
        end
        n = held_cnt;
        win[n] = req.in_byte;
        n++;
        h = 0;
        cnt = 0;
        while (h < n) begin
            lead = win[h];
            avail = n - h;
            take = 1;
            if (!lead[7]) begin
                if (lead == ChHyphen) begin
                    if (avail < 2 && !req.end_of_text) break;
                    next_ok = (avail >= 2) ? word_char(win[h+1]) : 1'b0;
                    out_bytes[cnt] = (prev_word_char && next_ok) ? ChHyphen : ChSpace;
                    cnt++;
                end else begin
                    out_bytes[cnt] = word_char(lead) ? fold_case(lead) : ChSpace;
                    cnt++;
                end
            end else begin
                if (lead[7:5] == 3'b110) need = 2;
                else if (lead[7:4] == 4'b1110) need = 3;
                else if (lead[7:3] == 5'b11110) need = 4;
                else need = 1;

                if (avail < need) begin
                    if (!req.end_of_text) break;
                    out_bytes[cnt] = ChSpace;
                    cnt++;
                end else if (need == 2) begin
                    nxt = win[h+1];
                    if (lead == LeadC3 && nxt >= ContLo && nxt <= ContHi) begin
                        if (nxt <= UpperHi && nxt != MulSign) nxt = nxt + CaseStep;
                        out_bytes[cnt] = lead;
                        out_bytes[cnt+1] = nxt;
                        cnt += 2;
                    end else begin
                        out_bytes[cnt] = ChSpace;
                        cnt++;
                    end
                    take = 2;
                end else begin
                    out_bytes[cnt] = ChSpace;
                    cnt++;
                    take = need;
                end
            end
            prev_word_char = word_char(win[h+take-1]);
            h += take;
        end

        for (int i = 0; i < cnt; i++) begin
            res.out_byte = out_bytes[i];
            res.out_last = req.end_of_text && (i == cnt - 1);
            norm_bytes_q.push_back(res);
        end

        if (req.end_of_text) begin
            held_cnt = 0;
            prev_word_char = 1'b0;
        end else begin
            for (int i = 0; i < n - h; i++) begin
                held_raw[i] = win[h+i];
            end
            held_cnt = n - h;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req want;

        if (!i_rst_n) begin
            norm_bytes_q.delete();
            held_cnt = 0;
            prev_word_char = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                normalize_byte(i_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (norm_bytes_q.size() == 0) begin
                    $error("out_byte: expected no request, got %02h (out_last %0b)",
                           i_out.out_byte, i_out.out_last);
                    mismatches++;
                end else begin
                    want = norm_bytes_q.pop_front();
                    if (i_out.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, i_out.out_byte);
                        mismatches++;
                    end
                    if (i_out.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               want.out_last, i_out.out_last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= norm_bytes_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[dv/testbench.sv]
module testbench;
    import utn_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int RandomItems  = 460;
    localparam int DrainCycles  = 16;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;
    int cycle_count = 0;

    utf8_text_normalizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    utn_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in.in_byte <= b;
        i_in.end_of_text <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [7:0] pick_word_char();
        int k;

        k = $urandom_range(0, 61);
        if (k < 10) return 8'("0" + k);
        if (k < 36) return 8'("A" + k - 10);
        return 8'("a" + k - 36);
    endfunction

    // build one text from mostly well-formed pieces, sometimes cut short
    task automatic send_text();
        logic [7:0] text_q [$];
        int         len;
        int         sel;

        len = $urandom_range(1, 12);
        while (text_q.size() < len) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                text_q.push_back(pick_word_char());
            end else if (sel < 45) begin
                text_q.push_back(ChHyphen);
            end else if (sel < 55) begin
                text_q.push_back(8'($urandom_range(0, 127)));
            end else if (sel < 70) begin
                text_q.push_back(LeadC3);
                text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (sel < 75) begin
                text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                text_q.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 80) begin
                text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (sel < 85) begin
                text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (text_q.size() > 1 && $urandom_range(0, 99) < 15) begin
            void'(text_q.pop_back());
        end
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(ChHyphen, 1'b0);
        send_byte("A",      1'b0);
        send_byte(ChHyphen, 1'b0);
        send_byte("z",      1'b0);
        send_byte(ChHyphen, 1'b1);
        send_byte(LeadC3,   1'b0);
        send_byte(8'h80,    1'b0);
        send_byte(LeadC3,   1'b0);
        send_byte(8'h97,    1'b0);
        send_byte(LeadC3,   1'b0);
        send_byte(8'h9E,    1'b0);
        send_byte(LeadC3,   1'b0);
        send_byte(8'hBF,    1'b0);
        send_byte(LeadC3,   1'b0);
        send_byte("A",      1'b0);
        send_byte(8'hE2,    1'b0);
        send_byte(8'h82,    1'b0);
        send_byte(8'hAC,    1'b0);
        send_byte(8'hF0,    1'b0);
        send_byte(8'h9F,    1'b0);
        send_byte(8'h98,    1'b0);
        send_byte(8'h80,    1'b0);
        send_byte(8'hFF,    1'b0);
        send_byte(8'hF4,    1'b0);
        send_byte(8'h90,    1'b1);

        sent_count = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            while (sent_count < (phase + 1) * RandomItems / 4) send_text();
        end

        i_in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
